// ----- hw/rtl/int_to_rle_packed_decimal_defines.svh -----
// Assertion macros shared by the RTL of the packed decimal encoder.
`ifndef INT_TO_RLE_PACKED_DECIMAL_DEFINES_SVH
`define INT_TO_RLE_PACKED_DECIMAL_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define IRPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define IRPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/irpd_pkg.sv -----
package irpd_pkg;

   localparam int VALUE_W        = 64;
   localparam int MAG_W          = 64;
   // The largest magnitude, 2**63, has 19 decimal digits.
   localparam int BCD_DIGITS     = 19;
   localparam int BITS_PER_STEP  = 4;
   localparam int DEF_MAX_DIGITS = 19;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [3:0] NIB_ZERO      = 4'h0;
   localparam logic [3:0] NIB_SIGN      = 4'hF;
   localparam logic [3:0] NIB_END       = 4'hF;
   localparam logic [3:0] NIB_RUN_SHORT = 4'hB;
   localparam logic [3:0] NIB_RUN_LONG  = 4'hC;

   localparam logic [7:0] RUN_SHORT_MIN = 8'd4;
   localparam logic [7:0] RUN_LONG_MIN  = 8'd16;

   typedef struct packed {
      logic       valid;
      logic [3:0] nib;
      logic       last;
   } nib_type;

endpackage

// ----- hw/rtl/irpd_channels.sv -----
interface irpd_req_if import irpd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface irpd_rsp_if import irpd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ----- hw/rtl/int_to_rle_packed_decimal.sv -----
// Signed 64-bit integer to run-length packed decimal. Each accepted value
// produces 1 to 11 result beats, one packed byte each, high nibble first;
// last marks the beat holding the closing F nibble. The front end takes a
// value, converts it to decimal four bits per cycle (16 steps) and aligns
// the digits; a two-entry queue then hands the digits to the back end. The
// back end walks the digits one per cycle, closes each run and puts out one
// nibble per cycle while the packer accepts it. The two ends overlap, so the
// sustained rate is set by the slower of the two, as long as the result side
// takes a beat every cycle.
module int_to_rle_packed_decimal import irpd_pkg::*; #(
   parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
   input  logic       clock,
   input  logic       reset,
   irpd_req_if.sink   req_bus,
   irpd_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int DIG_W = MAX_DIGITS * 4;
   localparam int Q_W   = DIG_W + CNT_W + 1;

   logic             fr_valid, fr_ready;
   logic [DIG_W-1:0] fr_digits, bk_digits;
   logic [CNT_W-1:0] fr_count, bk_count;
   logic             fr_neg, bk_neg;
   logic             bk_valid, bk_pop;
   logic [Q_W-1:0]   q_rd_data;
   nib_type          nib;
   logic             nib_ready;

   irpd_front #(
      .MAX_DIGITS (MAX_DIGITS),
      .CNT_W      (CNT_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_valid  (fr_valid),
      .q_ready  (fr_ready),
      .q_digits (fr_digits),
      .q_count  (fr_count),
      .q_neg    (fr_neg)
   );

   irpd_fifo #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_data  ({fr_digits, fr_count, fr_neg}),
      .rd_valid (bk_valid),
      .rd_ready (bk_pop),
      .rd_data  (q_rd_data)
   );

   assign {bk_digits, bk_count, bk_neg} = q_rd_data;

   irpd_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .CNT_W      (CNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (bk_valid),
      .q_pop     (bk_pop),
      .q_digits  (bk_digits),
      .q_count   (bk_count),
      .q_neg     (bk_neg),
      .nib_out   (nib),
      .nib_ready (nib_ready)
   );

   irpd_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .nib_in    (nib),
      .nib_ready (nib_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- hw/rtl/irpd_fifo.sv -----
module irpd_fifo import irpd_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              wr_acc, rd_acc;

   assign wr_ready = (fill_ff != FILL_W'(DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign wr_acc   = wr_valid && wr_ready;
   assign rd_acc   = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (wr_acc) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_acc) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_acc && !rd_acc) begin
         fill_in = fill_ff + 1'b1;
      end else if (rd_acc && !wr_acc) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_acc) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hw/rtl/irpd_front.sv -----
module irpd_front import irpd_pkg::*; #(
   parameter int MAX_DIGITS = DEF_MAX_DIGITS,
   parameter int CNT_W      = $clog2(DEF_MAX_DIGITS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   irpd_req_if.sink                req_bus,
   output logic                    q_valid,
   input  logic                    q_ready,
   output logic [MAX_DIGITS*4-1:0] q_digits,
   output logic [CNT_W-1:0]        q_count,
   output logic                    q_neg
);

   localparam int STEPS  = MAG_W / BITS_PER_STEP;
   localparam int STEP_W = $clog2(STEPS);
   localparam int BCD_W  = BCD_DIGITS * 4;
   localparam int DIG_W  = MAX_DIGITS * 4;
   localparam int ND_W   = $clog2(BCD_DIGITS + 1);
   localparam int ACC_W  = BCD_W + MAG_W;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CONV = 2'd1;
   localparam logic [1:0] F_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic              neg_ff, neg_in;
   logic [ND_W-1:0]   ndig;
   logic [CNT_W-1:0]  shift_amt;

   // Double dabble over BITS_PER_STEP (four) bits: add three to every digit of five or more,
   // then shift the binary value one place into the decimal digits.
   function automatic logic [ACC_W-1:0] dabble(input logic [ACC_W-1:0] acc);
      logic [ACC_W-1:0] a;
      logic [3:0]       dg;
      a = acc;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         for (int j = 0; j < BCD_DIGITS; j++) begin
            dg = a[MAG_W + 4*j +: 4];
            if (dg >= 4'd5) begin
               a[MAG_W + 4*j +: 4] = dg + 4'd3;
            end
         end
         a = a << 1;
      end
      return a;
   endfunction

   assign req_bus.ready = (state_ff == F_IDLE);
   assign q_valid       = (state_ff == F_DONE);
   assign q_neg         = neg_ff;

   // Keep the low digits only, with the most significant kept digit on top.
   always_comb begin
      ndig = '0;
      for (int j = 0; j < BCD_DIGITS; j++) begin
         if (bcd_ff[4*j +: 4] != 4'd0) begin
            ndig = ND_W'(j + 1);
         end
      end
      q_count   = (ndig > ND_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : CNT_W'(ndig);
      shift_amt = CNT_W'(MAX_DIGITS) - q_count;
      q_digits  = bcd_ff[DIG_W-1:0] << {shift_amt, 2'b00};
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_bus.valid) begin
               neg_in   = req_bus.value[VALUE_W-1];
               mag_in   = req_bus.value[VALUE_W-1] ?
                          (~$unsigned(req_bus.value) + 1'b1) : $unsigned(req_bus.value);
               bcd_in   = '0;
               step_in  = '0;
               state_in = F_CONV;
            end
         end
         F_CONV: begin
            {bcd_in, mag_in} = dabble({bcd_ff, mag_ff});
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = F_DONE;
            end
         end
         F_DONE: begin
            if (q_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
   end

endmodule

// ----- hw/rtl/irpd_back.sv -----
`include "int_to_rle_packed_decimal_defines.svh"

module irpd_back import irpd_pkg::*; #(
   parameter int MAX_DIGITS = DEF_MAX_DIGITS,
   parameter int CNT_W      = $clog2(DEF_MAX_DIGITS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  logic [MAX_DIGITS*4-1:0] q_digits,
   input  logic [CNT_W-1:0]        q_count,
   input  logic                    q_neg,
   output nib_type                 nib_out,
   input  logic                    nib_ready
);

   localparam int DIG_W = MAX_DIGITS * 4;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_SIGN  = 3'd1;
   localparam logic [2:0] B_START = 3'd2;
   localparam logic [2:0] B_SCAN  = 3'd3;
   localparam logic [2:0] B_EMIT  = 3'd4;
   localparam logic [2:0] B_END   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [DIG_W-1:0] sh_ff, sh_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic [3:0]       dig_ff, dig_in;
   logic [1:0]       k_ff, k_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;
   logic [3:0]       top;
   logic [7:0]       run8;
   logic             run_long, run_short;
   logic [1:0]       last_k;
   logic             nib_acc;

   assign top       = sh_ff[DIG_W-1 -: 4];
   assign run8      = 8'(run_ff);
   assign run_long  = (run8 >= RUN_LONG_MIN);
   assign run_short = (run8 >= RUN_SHORT_MIN);
   assign last_k    = run_long ? 2'd3 : (run_short ? 2'd2 : 2'(run_ff - 1'b1));
   assign nib_acc   = nib_out.valid && nib_ready;

   always_comb begin
      state_in      = state_ff;
      sh_in         = sh_ff;
      rem_in        = rem_ff;
      run_in        = run_ff;
      dig_in        = dig_ff;
      k_in          = k_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      q_pop         = 1'b0;
      nib_out.valid = 1'b0;
      nib_out.nib   = dig_ff;
      nib_out.last  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               sh_in    = q_digits;
               rem_in   = q_count;
               neg_in   = q_neg;
               zero_in  = (q_count == '0);
               state_in = B_SIGN;
            end
         end
         B_SIGN: begin
            // Zero goes out as a lone zero nibble ahead of the end marker.
            if (zero_ff) begin
               nib_out.valid = 1'b1;
               nib_out.nib   = NIB_ZERO;
               if (nib_acc) begin
                  state_in = B_END;
               end
            end else if (neg_ff) begin
               nib_out.valid = 1'b1;
               nib_out.nib   = NIB_SIGN;
               if (nib_acc) begin
                  state_in = B_START;
               end
            end else begin
               state_in = B_START;
            end
         end
         B_START: begin
            dig_in   = top;
            run_in   = CNT_W'(1);
            sh_in    = sh_ff << 4;
            rem_in   = rem_ff - 1'b1;
            state_in = B_SCAN;
         end
         B_SCAN: begin
            if ((rem_ff != '0) && (top == dig_ff)) begin
               run_in = run_ff + 1'b1;
               sh_in  = sh_ff << 4;
               rem_in = rem_ff - 1'b1;
            end else begin
               k_in     = 2'd0;
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            nib_out.valid = 1'b1;
            if (run_long) begin
               case (k_ff)
                  2'd0:    nib_out.nib = NIB_RUN_LONG;
                  2'd1:    nib_out.nib = dig_ff;
                  2'd2:    nib_out.nib = run8[7:4];
                  default: nib_out.nib = run8[3:0];
               endcase
            end else if (run_short) begin
               case (k_ff)
                  2'd0:    nib_out.nib = NIB_RUN_SHORT;
                  2'd1:    nib_out.nib = dig_ff;
                  default: nib_out.nib = run8[3:0];
               endcase
            end
            if (nib_acc) begin
               if (k_ff == last_k) begin
                  state_in = (rem_ff == '0) ? B_END : B_START;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         B_END: begin
            nib_out.valid = 1'b1;
            nib_out.nib   = NIB_END;
            nib_out.last  = 1'b1;
            if (nib_acc) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      run_ff  <= run_in;
      dig_ff  <= dig_in;
      k_ff    <= k_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   `IRPD_ASSERT_NOW(a_run_nonzero, clock, reset, (state_ff == B_SCAN) || (state_ff == B_EMIT), run_ff != '0, "digit run of length zero")
   `IRPD_ASSERT_NEXT(a_start_consumes, clock, reset, state_ff == B_START, (state_ff == B_SCAN) && (run_ff == CNT_W'(1)), "run start did not load one digit")

endmodule

// ----- hw/rtl/irpd_pack.sv -----
`include "int_to_rle_packed_decimal_defines.svh"

module irpd_pack import irpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  nib_type     nib_in,
   output logic        nib_ready,
   irpd_rsp_if.source  rsp_bus
);

   logic       half_ff, half_in;
   logic [3:0] pend_ff, pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       emit;
   logic       nib_acc;

   // A nibble that completes a byte, or the end marker, needs the output slot.
   assign emit      = half_ff || nib_in.last;
   assign nib_ready = !emit || !rsp_valid_ff || rsp_bus.ready;
   assign nib_acc   = nib_in.valid && nib_ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.data_byte = rsp_data_ff;
   assign rsp_bus.last      = rsp_last_ff;

   always_comb begin
      half_in      = half_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (nib_acc) begin
         if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = half_ff ? {pend_ff, nib_in.nib} : {nib_in.nib, 4'h0};
            rsp_last_in  = nib_in.last;
            half_in      = 1'b0;
         end else begin
            pend_in = nib_in.nib;
            half_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `IRPD_ASSERT_NEXT(a_end_flushes, clock, reset, nib_acc && nib_in.last, rsp_valid_ff && rsp_last_ff && !half_ff, "end nibble did not close the stream")
   `IRPD_ASSERT_NEXT(a_pair_emits, clock, reset, nib_acc && half_ff, rsp_valid_ff && !half_ff, "completed byte was not presented")
   `IRPD_ASSERT_NEXT(a_half_holds, clock, reset, nib_acc && !half_ff && !nib_in.last, half_ff, "high nibble was not held")

endmodule
